>>> design/ptst_pkg.sv
// Shared types, codes and defaults for the periodic timer slot table.
// No dependencies; compile first.
package ptst_pkg;

    localparam int SLOT_COUNT_DEF  = 16;
    localparam int PERIOD_BITS_DEF = 24;
    localparam int RESULT_CAP      = 16;
    localparam int FIRE_CNT_W      = $clog2(RESULT_CAP + 1);
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    // input kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // reply kinds
    localparam logic [1:0] REPLY_FIRE   = 2'd0;
    localparam logic [1:0] REPLY_ADD    = 2'd1;
    localparam logic [1:0] REPLY_REMOVE = 2'd2;
    localparam logic [1:0] REPLY_CLEAR  = 2'd3;

    // register index of timer_enabled (paddr[2])
    localparam logic REG_TIMER_ENABLED = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] handle;
        logic [23:0] interval_ticks;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [3:0]  slot_index;
        logic [15:0] client_handle;
        logic        success;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_WALK,
        CTL_FLUSH
    } ctl_state_t;

    typedef struct packed {
        logic load;     // latch item, start slot walk
        logic clear;    // free every slot, queue clear reply
        logic finish;   // walk over, queue failure reply if needed
        logic flush;    // push last pending reply out
    } ptst_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic pend_vld;
        logic out_free;
    } ptst_status_t;

endpackage

>>> design/periodic_timer_slot_table_top.sv
// Tick walks every slot once; add and remove walk the slots in order and stop
//   early at their slot. Clear and disabled ticks need no slot walk.
// Items are taken one at a time, only when the controller is idle; the walk reads
//   one slot per cycle from the slot stores unless a reply stall holds it.
// Reset: synchronous, active low; frees all slots, disables the timer,
//   empties the output register. No clearing pass.
module periodic_timer_slot_table_top #(
    parameter int SLOT_COUNT  = ptst_pkg::SLOT_COUNT_DEF,
    parameter int PERIOD_BITS = ptst_pkg::PERIOD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // item input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ptst_pkg::in_item_t            s_data,
    // reply output
    output logic                          m_valid,
    input  logic                          m_ready,
    output ptst_pkg::out_item_t           m_data,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptst_pkg::PADDR_W-1:0]  paddr,
    input  logic [ptst_pkg::PDATA_W-1:0]  pwdata,
    output logic [ptst_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ptst_pkg::*;

    logic         timer_en_reg;
    ptst_cmd_t    ctl_cmd;
    ptst_status_t dp_status;

    // Register file: only timer_enabled at byte 0. Writes land on the
    // access cycle; the controller only looks at it when idle.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_en_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_TIMER_ENABLED) begin
            timer_en_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TIMER_ENABLED) begin
            prdata[0] = timer_en_reg;
        end
    end

    // Controller decides what each accepted item starts; the datapath
    // walks the slots and stages replies so that last_of_run is known.
    ptst_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_data.kind),
        .timer_enabled (timer_en_reg),
        .status        (dp_status),
        .cmd           (ctl_cmd)
    );

    ptst_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (ctl_cmd),
        .status  (dp_status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A clear always stages its reply on the next cycle.
    a_clear_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == KIND_CLEAR |=> dp_status.pend_vld)
        else $error("clear item did not stage a reply");

    // A tick with the timer off is dropped and the block stays open.
    a_tick_off: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == KIND_TICK && !timer_en_reg |=> s_ready)
        else $error("disabled tick started work");

    // Starting a walk must leave the walk busy on the next cycle.
    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.load |=> !dp_status.walk_done && !s_ready)
        else $error("slot walk did not start");

endmodule

>>> design/ptst_ctrl.sv
// Controller FSM for the periodic timer slot table.
// Depends on ptst_pkg.
module ptst_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic                  timer_enabled,
    input  ptst_pkg::ptst_status_t status,
    output ptst_pkg::ptst_cmd_t    cmd
);
    import ptst_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_CLEAR) begin
                        state_next = CTL_FLUSH;
                    end else if (s_kind != KIND_TICK || timer_enabled) begin
                        state_next = CTL_WALK;
                    end
                end
            end
            CTL_WALK: begin
                if (status.walk_done) begin
                    state_next = CTL_FLUSH;
                end
            end
            CTL_FLUSH: begin
                if (!status.pend_vld || status.out_free) begin
                    state_next = CTL_IDLE;
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            CTL_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (s_kind == KIND_CLEAR) begin
                        cmd.clear = 1'b1;
                    end else if (s_kind != KIND_TICK || timer_enabled) begin
                        cmd.load = 1'b1;
                    end
                end
            end
            CTL_WALK: begin
                cmd.finish = status.walk_done;
            end
            CTL_FLUSH: begin
                cmd.flush = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/ptst_datapath.sv
// Datapath: slot stores, valid bits, slot walk pipeline, reply staging
// and output register. Depends on ptst_pkg.
module ptst_datapath #(
    parameter int SLOT_COUNT  = ptst_pkg::SLOT_COUNT_DEF,
    parameter int PERIOD_BITS = ptst_pkg::PERIOD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ptst_pkg::in_item_t     s_data,
    input  ptst_pkg::ptst_cmd_t    cmd,
    output ptst_pkg::ptst_status_t status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ptst_pkg::out_item_t    m_data
);
    import ptst_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [PERIOD_BITS-1:0] CNT_MAX  = {PERIOD_BITS{1'b1}};

    // slot stores (written by add / tick, read one slot per cycle unless a reply stall holds the walk)
    logic [15:0]            client_mem  [SLOT_COUNT];
    logic [PERIOD_BITS-1:0] period_mem  [SLOT_COUNT];
    logic [PERIOD_BITS-1:0] elapsed_mem [SLOT_COUNT];

    logic [SLOT_COUNT-1:0]  valid_reg;

    // latched item
    logic [1:0]             op_kind_reg;
    logic [15:0]            op_handle_reg;
    logic [PERIOD_BITS-1:0] op_ivl_reg;

    // walk pipeline
    logic                   rd_active_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   ev_vld_reg;
    logic [IDX_W-1:0]       ev_idx_reg;
    logic                   found_reg;
    logic [FIRE_CNT_W-1:0]  fire_cnt_reg;
    logic [15:0]            rd_client_reg;
    logic [PERIOD_BITS-1:0] rd_period_reg;
    logic [PERIOD_BITS-1:0] rd_elapsed_reg;

    // reply staging and output
    logic                   pend_vld_reg;
    out_item_t              pend_reg;
    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    logic                   ev_act, slot_v, is_tick;
    logic [PERIOD_BITS-1:0] elapsed_inc, elapsed_next;
    logic                   fire, fire_rep, add_hit, rem_hit, hit, push;
    logic                   out_free, step, issue;
    logic                   elapsed_we;
    out_item_t              new_reply;

    assign out_free = !m_valid_reg || m_ready;

    assign ev_act  = ev_vld_reg && !found_reg;
    assign slot_v  = valid_reg[ev_idx_reg];
    assign is_tick = (op_kind_reg == KIND_TICK);

    // saturating increment, restart on reaching the interval
    assign elapsed_inc  = (rd_elapsed_reg == CNT_MAX) ? rd_elapsed_reg
                                                      : rd_elapsed_reg + PERIOD_BITS'(1);
    assign fire         = ev_act && is_tick && slot_v && (elapsed_inc >= rd_period_reg);
    assign elapsed_next = fire ? '0 : elapsed_inc;
    assign fire_rep     = fire && (fire_cnt_reg < FIRE_CNT_W'(RESULT_CAP));

    assign add_hit = ev_act && (op_kind_reg == KIND_ADD) && !slot_v;
    assign rem_hit = ev_act && (op_kind_reg == KIND_REMOVE) && slot_v
                     && (rd_client_reg == op_handle_reg);
    assign hit     = add_hit || rem_hit;
    assign push    = fire_rep || hit;

    // stall only when a new reply needs the staging slot and output is full
    assign step  = !(push && pend_vld_reg && !out_free);
    assign issue = rd_active_reg && step && !hit;

    assign elapsed_we = step && ((ev_act && is_tick && slot_v) || add_hit);

    always_comb begin
        new_reply.reply_kind    = fire ? REPLY_FIRE : op_kind_reg;
        new_reply.slot_index    = 4'(ev_idx_reg);
        new_reply.client_handle = fire ? rd_client_reg : op_handle_reg;
        new_reply.success       = !fire;
        new_reply.last_of_run   = 1'b0;
    end

    // stores
    always_ff @(posedge aclk) begin
        if (step && add_hit) begin
            client_mem[ev_idx_reg] <= op_handle_reg;
            period_mem[ev_idx_reg] <= op_ivl_reg;
        end
        if (elapsed_we) begin
            elapsed_mem[ev_idx_reg] <= add_hit ? '0 : elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_client_reg  <= client_mem[rd_idx_reg];
            rd_period_reg  <= period_mem[rd_idx_reg];
            rd_elapsed_reg <= elapsed_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.clear) begin
            valid_reg <= '0;
        end else if (step && add_hit) begin
            valid_reg[ev_idx_reg] <= 1'b1;
        end else if (step && rem_hit) begin
            valid_reg[ev_idx_reg] <= 1'b0;
        end
    end

    // walk control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_active_reg <= 1'b0;
            ev_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end else if (cmd.load) begin
            rd_active_reg <= 1'b1;
            rd_idx_reg    <= '0;
            ev_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            fire_cnt_reg  <= '0;
            op_kind_reg   <= s_data.kind;
            op_handle_reg <= s_data.handle;
            op_ivl_reg    <= PERIOD_BITS'(s_data.interval_ticks);
        end else if (step) begin
            ev_vld_reg <= issue;
            ev_idx_reg <= rd_idx_reg;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                if (rd_idx_reg == LAST_IDX) begin
                    rd_active_reg <= 1'b0;
                end
            end
            if (hit) begin
                found_reg     <= 1'b1;
                rd_active_reg <= 1'b0;
            end
            if (fire_rep) begin
                fire_cnt_reg <= fire_cnt_reg + FIRE_CNT_W'(1);
            end
        end
    end

    // reply staging: a reply waits until the next one shows whether it is last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.clear) begin
                pend_vld_reg           <= 1'b1;
                pend_reg.reply_kind    <= REPLY_CLEAR;
                pend_reg.slot_index    <= '0;
                pend_reg.client_handle <= '0;
                pend_reg.success       <= 1'b1;
                pend_reg.last_of_run   <= 1'b0;
            end else if (cmd.finish) begin
                if (!is_tick && !found_reg) begin
                    pend_vld_reg           <= 1'b1;
                    pend_reg.reply_kind    <= op_kind_reg;
                    pend_reg.slot_index    <= '0;
                    pend_reg.client_handle <= op_handle_reg;
                    pend_reg.success       <= 1'b0;
                    pend_reg.last_of_run   <= 1'b0;
                end
            end else if (cmd.flush) begin
                if (pend_vld_reg && out_free) begin
                    m_data_reg             <= pend_reg;
                    m_data_reg.last_of_run <= 1'b1;
                    m_valid_reg            <= 1'b1;
                    pend_vld_reg           <= 1'b0;
                end
            end else if (push && step) begin
                if (pend_vld_reg) begin
                    m_data_reg  <= pend_reg;
                    m_valid_reg <= 1'b1;
                end
                pend_reg     <= new_reply;
                pend_vld_reg <= 1'b1;
            end
        end
    end

    assign status.walk_done = !rd_active_reg && !ev_vld_reg;
    assign status.pend_vld  = pend_vld_reg;
    assign status.out_free  = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
